### rtl/core/kvpt_pkg.sv
// Shared types, codes and character classes for the key/value pair tokenizer.
// Stands alone; the tokenizer core refers to it by scoped names.
`default_nettype none

package kvpt_pkg;

	typedef enum logic [2:0] {
		PH_SKIP   = 3'd0,
		PH_KEY    = 3'd1,
		PH_EQ     = 3'd2,
		PH_PLAIN  = 3'd3,
		PH_QUOTED = 3'd4,
		PH_ESC    = 3'd5,
		PH_CLOSED = 3'd6
	} phase_t;

	typedef logic [2:0] err_t;
	typedef logic [1:0] kind_t;

	localparam err_t ERR_NONE      = 3'd0;
	localparam err_t ERR_KEY_CHAR  = 3'd1;
	localparam err_t ERR_DIGIT_1ST = 3'd2;
	localparam err_t ERR_EMPTY_KEY = 3'd3;
	localparam err_t ERR_NO_EQUALS = 3'd4;
	localparam err_t ERR_NO_VALUE  = 3'd5;
	localparam err_t ERR_QUOTE     = 3'd6;
	localparam err_t ERR_NO_SPACE  = 3'd7;

	localparam kind_t KIND_SKIP  = 2'd0;
	localparam kind_t KIND_KEY   = 2'd1;
	localparam kind_t KIND_VALUE = 2'd2;
	localparam kind_t KIND_DELIM = 2'd3;

	localparam logic [7:0] CH_EQUALS = 8'h3D;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_UNDER  = 8'h5F;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == 8'd32) || (c inside {[8'd9:8'd13]});
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_keychar(input logic [7:0] c);
		return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) ||
			(c == CH_UNDER);
	endfunction

endpackage

`default_nettype wire

### rtl/core/key_value_pair_tokenizer.sv
// Key/value pair tokenizer: one character request in, one result request out.
// Depends on kvpt_pkg for phase type, error and kind codes, character classes.
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+---------------------------------------------
//  char     | char_valid / char_stall| char_in[7:0], msg_last
//  result   | res_valid / res_stall  | char_kind[1:0], data_byte[7:0], pair_end,
//           |                        | error_code[2:0], msg_done
//
//  An accepted character passes through the input register and then the
//  result register. One character a cycle is sustained while res_stall is
//  low; the parse state registers are updated by one short decode as a
//  character moves from the input register to the result register.
//  arst_n clears the parse state and both valid flags; payload holds no reset.
//  A stalled result holds the result register, then the input register, and
//  char_stall rises only once both are full.
`default_nettype none

module key_value_pair_tokenizer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       char_valid,
	output logic            char_stall,
	input  wire logic [7:0] char_in,
	input  wire logic       msg_last,
	output logic            res_valid,
	input  wire logic       res_stall,
	output logic [1:0]      char_kind,
	output logic [7:0]      data_byte,
	output logic            pair_end,
	output logic [2:0]      error_code,
	output logic            msg_done
);

	// Input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// Parse state
	kvpt_pkg::phase_t phase_q;
	logic             quote_single_q;
	kvpt_pkg::err_t   err_q;

	// Result register
	logic             valid_s2;
	kvpt_pkg::kind_t  kind_s2;
	logic [7:0]       data_s2;
	logic             pend_s2;
	kvpt_pkg::err_t   err_s2;
	logic             last_s2;

	// Decode results
	kvpt_pkg::phase_t phase_step;
	logic             quote_step;
	kvpt_pkg::err_t   err_new;
	kvpt_pkg::phase_t phase_d;
	logic             quote_d;
	kvpt_pkg::err_t   err_d;
	kvpt_pkg::kind_t  kind_d;
	logic [7:0]       data_d;
	logic             pend_d;
	logic [7:0]       quote_ch;

	logic hold_s2;
	logic adv_s2;
	logic hold_s1;

	// Hold the result while it is stalled; the input register drains into it
	// whenever it is free.
	assign hold_s2    = valid_s2 & res_stall;
	assign adv_s2     = ~hold_s2;
	assign hold_s1    = valid_s1 & hold_s2;
	assign char_stall = hold_s1;

	assign quote_ch = quote_single_q ? kvpt_pkg::CH_SQUOTE : kvpt_pkg::CH_DQUOTE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!hold_s1) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold_s1 && char_valid) begin
			char_s1 <= char_in;
			last_s1 <= msg_last;
		end
	end

	// Next state: phase transition, quote choice and error detection.
	always_comb begin
		phase_step = phase_q;
		quote_step = quote_single_q;
		err_new    = kvpt_pkg::ERR_NONE;
		if (err_q == kvpt_pkg::ERR_NONE) begin
			case (phase_q)
				kvpt_pkg::PH_SKIP: begin
					if (kvpt_pkg::is_blank(char_s1)) begin
						phase_step = kvpt_pkg::PH_SKIP;
					end else if (char_s1 == kvpt_pkg::CH_EQUALS) begin
						err_new = kvpt_pkg::ERR_EMPTY_KEY;
					end else if (!kvpt_pkg::is_keychar(char_s1)) begin
						err_new = kvpt_pkg::ERR_KEY_CHAR;
					end else if (kvpt_pkg::is_digit(char_s1)) begin
						err_new = kvpt_pkg::ERR_DIGIT_1ST;
					end else begin
						phase_step = kvpt_pkg::PH_KEY;
					end
				end
				kvpt_pkg::PH_KEY: begin
					if (kvpt_pkg::is_blank(char_s1)) begin
						err_new = kvpt_pkg::ERR_NO_EQUALS;
					end else if (char_s1 == kvpt_pkg::CH_EQUALS) begin
						phase_step = kvpt_pkg::PH_EQ;
					end else if (!kvpt_pkg::is_keychar(char_s1)) begin
						err_new = kvpt_pkg::ERR_KEY_CHAR;
					end
				end
				kvpt_pkg::PH_EQ: begin
					if (kvpt_pkg::is_blank(char_s1)) begin
						err_new = kvpt_pkg::ERR_NO_VALUE;
					end else if (char_s1 == kvpt_pkg::CH_DQUOTE ||
						char_s1 == kvpt_pkg::CH_SQUOTE) begin
						quote_step = (char_s1 == kvpt_pkg::CH_SQUOTE);
						phase_step = kvpt_pkg::PH_QUOTED;
					end else begin
						phase_step = kvpt_pkg::PH_PLAIN;
					end
				end
				kvpt_pkg::PH_PLAIN: begin
					if (kvpt_pkg::is_blank(char_s1)) begin
						phase_step = kvpt_pkg::PH_SKIP;
					end
				end
				kvpt_pkg::PH_QUOTED: begin
					if (char_s1 == kvpt_pkg::CH_BSLASH) begin
						phase_step = kvpt_pkg::PH_ESC;
					end else if (char_s1 == quote_ch) begin
						phase_step = kvpt_pkg::PH_CLOSED;
					end
				end
				kvpt_pkg::PH_ESC: begin
					if (char_s1 == kvpt_pkg::CH_BSLASH || char_s1 == quote_ch) begin
						phase_step = kvpt_pkg::PH_QUOTED;
					end else begin
						err_new = kvpt_pkg::ERR_QUOTE;
					end
				end
				kvpt_pkg::PH_CLOSED: begin
					if (kvpt_pkg::is_blank(char_s1)) begin
						phase_step = kvpt_pkg::PH_SKIP;
					end else begin
						err_new = kvpt_pkg::ERR_NO_SPACE;
					end
				end
				default: begin
					phase_step = kvpt_pkg::PH_SKIP;
				end
			endcase

			// Message end while a pair is still open
			if (err_new == kvpt_pkg::ERR_NONE && last_s1) begin
				case (phase_step)
					kvpt_pkg::PH_KEY:    err_new = kvpt_pkg::ERR_NO_EQUALS;
					kvpt_pkg::PH_EQ:     err_new = kvpt_pkg::ERR_NO_VALUE;
					kvpt_pkg::PH_QUOTED: err_new = kvpt_pkg::ERR_QUOTE;
					kvpt_pkg::PH_ESC:    err_new = kvpt_pkg::ERR_QUOTE;
					default:             err_new = kvpt_pkg::ERR_NONE;
				endcase
			end
		end

		// Drop all state at the end of a message
		if (last_s1) begin
			phase_d = kvpt_pkg::PH_SKIP;
			quote_d = 1'b0;
			err_d   = kvpt_pkg::ERR_NONE;
		end else begin
			phase_d = phase_step;
			quote_d = quote_step;
			err_d   = (err_q != kvpt_pkg::ERR_NONE) ? err_q : err_new;
		end
	end

	// Outputs: class, unescaped byte and pair end for the current character.
	always_comb begin
		kind_d = kvpt_pkg::KIND_SKIP;
		data_d = 8'd0;
		pend_d = 1'b0;
		case (phase_q)
			kvpt_pkg::PH_SKIP: begin
				if (phase_step == kvpt_pkg::PH_KEY) begin
					kind_d = kvpt_pkg::KIND_KEY;
					data_d = char_s1;
				end
			end
			kvpt_pkg::PH_KEY: begin
				if (char_s1 == kvpt_pkg::CH_EQUALS) begin
					kind_d = kvpt_pkg::KIND_DELIM;
				end else begin
					kind_d = kvpt_pkg::KIND_KEY;
					data_d = char_s1;
				end
			end
			kvpt_pkg::PH_EQ: begin
				if (phase_step == kvpt_pkg::PH_QUOTED) begin
					kind_d = kvpt_pkg::KIND_DELIM;
				end else begin
					kind_d = kvpt_pkg::KIND_VALUE;
					data_d = char_s1;
				end
			end
			kvpt_pkg::PH_PLAIN: begin
				if (kvpt_pkg::is_blank(char_s1)) begin
					pend_d = 1'b1;
				end else begin
					kind_d = kvpt_pkg::KIND_VALUE;
					data_d = char_s1;
				end
			end
			kvpt_pkg::PH_QUOTED: begin
				if (char_s1 == quote_ch) begin
					kind_d = kvpt_pkg::KIND_DELIM;
				end else if (char_s1 != kvpt_pkg::CH_BSLASH) begin
					kind_d = kvpt_pkg::KIND_VALUE;
					data_d = char_s1;
				end
			end
			kvpt_pkg::PH_ESC: begin
				kind_d = kvpt_pkg::KIND_VALUE;
				data_d = char_s1;
			end
			kvpt_pkg::PH_CLOSED: begin
				pend_d = 1'b1;
			end
			default: begin
				kind_d = kvpt_pkg::KIND_SKIP;
			end
		endcase

		// A value still open at the message end completes the pair here
		if (last_s1 && (phase_step == kvpt_pkg::PH_PLAIN ||
			phase_step == kvpt_pkg::PH_CLOSED)) begin
			pend_d = 1'b1;
		end

		// Any error, latched or fresh, blanks the character
		if (err_q != kvpt_pkg::ERR_NONE || err_new != kvpt_pkg::ERR_NONE) begin
			kind_d = kvpt_pkg::KIND_SKIP;
			data_d = 8'd0;
			pend_d = 1'b0;
		end
	end

	// Advance the parse state as a character moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= kvpt_pkg::PH_SKIP;
			quote_single_q <= 1'b0;
			err_q          <= kvpt_pkg::ERR_NONE;
			valid_s2       <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				phase_q        <= phase_d;
				quote_single_q <= quote_d;
				err_q          <= err_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			kind_s2 <= kind_d;
			data_s2 <= data_d;
			pend_s2 <= pend_d;
			err_s2  <= (err_q != kvpt_pkg::ERR_NONE) ? err_q : err_new;
			last_s2 <= last_s1;
		end
	end

	assign res_valid  = valid_s2;
	assign char_kind  = kind_s2;
	assign data_byte  = data_s2;
	assign pair_end   = pend_s2;
	assign error_code = err_s2;
	assign msg_done   = last_s2;

	// A byte is reported only for key and value characters.
	a_data_only_for_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (char_kind == kvpt_pkg::KIND_SKIP ||
		char_kind == kvpt_pkg::KIND_DELIM) |-> data_byte == 8'd0)
		else $error("data byte set on a skipped or delimiter result");

	// An error blanks the result.
	a_error_blanks: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && error_code != kvpt_pkg::ERR_NONE |->
		char_kind == kvpt_pkg::KIND_SKIP && !pair_end)
		else $error("error result carries a token");

	// The last character of a message leaves the parser at reset values.
	a_msg_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 && valid_s1 && last_s1 |=>
		phase_q == kvpt_pkg::PH_SKIP && err_q == kvpt_pkg::ERR_NONE && !quote_single_q)
		else $error("parse state not cleared at message end");

	// A latched error stays until the message ends.
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q != kvpt_pkg::ERR_NONE && !(adv_s2 && valid_s1 && last_s1) |=>
		err_q == $past(err_q))
		else $error("latched error changed inside a message");

endmodule

`default_nettype wire
